[rtl/mma_pkg.sv]
// shared constants, result record and indication codes of the moving average alarm
// no dependencies
package mma_pkg;

  localparam int WINDOW_LEN   = 10;
  localparam int NUM_CHANNELS = 4;

  localparam int CH_W     = 2;
  localparam int SAMPLE_W = 16;
  localparam int ALARM_W  = 2;

  localparam int CHIDX_W     = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int POS_W       = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int SUM_W       = SAMPLE_W + $clog2(WINDOW_LEN);
  localparam int STORE_DEPTH = NUM_CHANNELS * WINDOW_LEN;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  // divide by window length as multiply by rounded-up reciprocal
  localparam int DIV_SHIFT    = SUM_W + $clog2(WINDOW_LEN);
  localparam int DIV_MULT_W   = SUM_W + 1;
  localparam int PROD_W       = SUM_W + DIV_MULT_W;
  localparam int Q_W          = SAMPLE_W + 1;
  localparam longint DivMultL = ((64'sd1 <<< DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
  localparam logic [DIV_MULT_W-1:0] DIV_MULT = DIV_MULT_W'(DivMultL);

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic signed [SAMPLE_W-1:0] THRESHOLD_RESET = 16'sd19000;
  localparam logic signed [SAMPLE_W-1:0] MIN_RESET       = 16'sd32767;
  localparam logic signed [SAMPLE_W-1:0] MAX_RESET       = 16'sd0;

  typedef enum logic [ALARM_W-1:0] {
    IND_IDLE  = 2'd0,
    IND_OK    = 2'd1,
    IND_ALARM = 2'd2
  } alarm_e;

  typedef struct packed {
    logic [CH_W-1:0]            out_channel;
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SAMPLE_W-1:0] minimum;
    logic signed [SAMPLE_W-1:0] maximum;
    alarm_e                     alarm_state;
  } result_t;

endpackage

[rtl/mma_in_if.sv]
// sample channel: valid/ready handshake with channel tag and signed sample
// depends on mma_pkg
interface mma_in_if import mma_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            channel;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, channel, sample, input ready);
  modport sink   (input valid, channel, sample, output ready);
endinterface

[rtl/mma_out_if.sv]
// result channel: valid/ready handshake with per-channel statistics and indication
// depends on mma_pkg
interface mma_out_if import mma_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [CH_W-1:0]            out_channel;
  logic signed [SAMPLE_W-1:0] average;
  logic signed [SAMPLE_W-1:0] minimum;
  logic signed [SAMPLE_W-1:0] maximum;
  logic [ALARM_W-1:0]         alarm_state;

  modport source (output valid, out_channel, average, minimum, maximum, alarm_state,
                  input ready);
  modport sink   (input valid, out_channel, average, minimum, maximum, alarm_state,
                  output ready);
endinterface

[rtl/mma_ram.sv]
// generic single-write, single-read synchronous ram with registered read data
// no dependencies
module mma_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 40
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/mma_out_fifo.sv]
// result queue between the update pipeline and the output channel
// depends on mma_pkg
module mma_out_fifo import mma_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  result_t               push_data_i,
  input  logic                  pop_i,
  output result_t               head_o,
  output logic                  valid_o,
  output logic [FIFO_CNT_W-1:0] count_o
);

  result_t               mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CNT_W-1:0] count_q, count_d;

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + FIFO_CNT_W'(1);
    end else if (pop_i && !push_i) begin
      count_d = count_q - FIFO_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + FIFO_PTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + FIFO_PTR_W'(1);
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assign head_o  = mem_q[rd_ptr_q];
  assign valid_o = (count_q != '0);
  assign count_o = count_q;

endmodule

[rtl/multichannel_moving_average_alarm.sv]
// Multichannel boxcar moving average with per-channel minimum and maximum and a
// threshold alarm over the channel 0 and channel 1 averages.
// Channels: in_i carries a channel tag and a signed sample, out_o carries one
// result per sample transfer (channel, window average, minimum, maximum, indication).
// cfg_we_i/cfg_wdata_i write the signed alarm threshold; write it only while idle.
// Path: a result passes the pipeline stage registers and then the result queue before it is offered.
// Throughput: one sample per cycle while in_i.ready is high; the window ram is read
// as a sample is taken and written back in the cycle after, with a one-entry bypass
// for a back-to-back read of the entry just written.
// Reset: per-entry valid flags mark the window ram as all zero at once, so
// samples are taken as soon as reset is released; sums, positions and
// averages clear, minima start at 32767, maxima at 0, indication idle.
// Stall: an 8-entry result queue absorbs a stalled receiver; in_i.ready drops
// when queued plus in-flight results reach 8, and nothing is lost.
// depends on mma_pkg, mma_in_if, mma_out_if, mma_ram, mma_out_fifo
module multichannel_moving_average_alarm import mma_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [SAMPLE_W-1:0] cfg_wdata_i,
  mma_in_if.sink              in_i,
  mma_out_if.source           out_o
);

  logic signed [SAMPLE_W-1:0] threshold_q;
  logic [POS_W-1:0]           pos_q [NUM_CHANNELS];
  logic signed [SUM_W-1:0]    sum_q [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0] min_q [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0] max_q [NUM_CHANNELS];
  logic signed [SAMPLE_W-1:0] avg_q [NUM_CHANNELS];
  logic [STORE_DEPTH-1:0]     stored_q;
  alarm_e                     ind_q, ind_d;

  // intake
  logic               in_xfer, in_ok, rd_en;
  logic [CHIDX_W-1:0] in_idx;
  logic [ADDR_W-1:0]  rd_addr;

  // stage 1: window read returns
  logic                       s1_valid_q;
  logic [CH_W-1:0]            s1_ch_q;
  logic signed [SAMPLE_W-1:0] s1_sample_q;
  logic [ADDR_W-1:0]          s1_addr_q;
  logic [CHIDX_W-1:0]         s1_idx;
  logic [SAMPLE_W-1:0]        ram_rdata;
  logic signed [SAMPLE_W-1:0] old_sample;
  logic signed [SUM_W-1:0]    sum_new;
  logic signed [SAMPLE_W-1:0] min_new, max_new;

  // last write bypass
  logic                       lw_valid_q;
  logic [ADDR_W-1:0]          lw_addr_q;
  logic signed [SAMPLE_W-1:0] lw_data_q;

  // stage 2: reciprocal multiply
  logic                       s2_valid_q;
  logic [CH_W-1:0]            s2_ch_q;
  logic signed [SUM_W-1:0]    s2_sum_q;
  logic signed [SAMPLE_W-1:0] s2_min_q, s2_max_q;
  logic                       s2_neg;
  logic [SUM_W-1:0]           s2_mag;
  logic [PROD_W-1:0]          s2_prod;

  // stage 3: average and indication
  logic                       s3_valid_q;
  logic [CH_W-1:0]            s3_ch_q;
  logic                       s3_neg_q;
  logic [PROD_W-1:0]          s3_prod_q;
  logic signed [SAMPLE_W-1:0] s3_min_q, s3_max_q;
  logic [CHIDX_W-1:0]         s3_idx;
  logic [Q_W-1:0]             s3_quot;
  logic signed [SAMPLE_W-1:0] avg_new, avg_a0, avg_a1;
  result_t                    push_data;

  // output queue
  result_t               head;
  logic                  fifo_valid, pop;
  logic [FIFO_CNT_W-1:0] fifo_count;
  logic [FIFO_CNT_W:0]   occupancy;

  assign in_xfer = in_i.valid && in_i.ready;
  assign in_ok   = int'(in_i.channel) < NUM_CHANNELS;
  assign in_idx  = CHIDX_W'(in_i.channel);
  assign rd_en   = in_xfer && in_ok;
  assign rd_addr = ADDR_W'(ADDR_W'(in_idx) * ADDR_W'(WINDOW_LEN)) + ADDR_W'(pos_q[in_idx]);

  assign occupancy = (FIFO_CNT_W+1)'(fifo_count) + (FIFO_CNT_W+1)'(s1_valid_q)
                   + (FIFO_CNT_W+1)'(s2_valid_q) + (FIFO_CNT_W+1)'(s3_valid_q);
  assign in_i.ready = occupancy < (FIFO_CNT_W+1)'(FIFO_DEPTH);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      threshold_q <= $signed(cfg_wdata_i);
    end
  end

  // write position advances at the intake transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        pos_q[c] <= '0;
      end
    end else if (rd_en) begin
      if (pos_q[in_idx] == POS_W'(WINDOW_LEN - 1)) begin
        pos_q[in_idx] <= '0;
      end else begin
        pos_q[in_idx] <= pos_q[in_idx] + POS_W'(1);
      end
    end
  end

  mma_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (STORE_DEPTH)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (s1_valid_q),
    .waddr_i (s1_addr_q),
    .wdata_i (s1_sample_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (ram_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      lw_valid_q <= 1'b0;
      stored_q   <= '0;
    end else begin
      s1_valid_q <= rd_en;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      lw_valid_q <= s1_valid_q;
      if (s1_valid_q) begin
        stored_q[s1_addr_q] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      s1_ch_q     <= in_i.channel;
      s1_sample_q <= in_i.sample;
      s1_addr_q   <= rd_addr;
    end
    lw_addr_q <= s1_addr_q;
    lw_data_q <= s1_sample_q;
    s2_ch_q   <= s1_ch_q;
    s2_sum_q  <= sum_new;
    s2_min_q  <= min_new;
    s2_max_q  <= max_new;
    s3_ch_q   <= s2_ch_q;
    s3_neg_q  <= s2_neg;
    s3_prod_q <= s2_prod;
    s3_min_q  <= s2_min_q;
    s3_max_q  <= s2_max_q;
  end

  // running sum, minimum and maximum
  assign s1_idx = CHIDX_W'(s1_ch_q);

  always_comb begin
    if (lw_valid_q && (lw_addr_q == s1_addr_q)) begin
      old_sample = lw_data_q;
    end else if (stored_q[s1_addr_q]) begin
      old_sample = $signed(ram_rdata);
    end else begin
      old_sample = '0;
    end
    sum_new = sum_q[s1_idx] - SUM_W'(old_sample) + SUM_W'(s1_sample_q);
    min_new = (s1_sample_q < min_q[s1_idx]) ? s1_sample_q : min_q[s1_idx];
    max_new = (s1_sample_q > max_q[s1_idx]) ? s1_sample_q : max_q[s1_idx];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        sum_q[c] <= '0;
        min_q[c] <= MIN_RESET;
        max_q[c] <= MAX_RESET;
      end
    end else if (s1_valid_q) begin
      sum_q[s1_idx] <= sum_new;
      min_q[s1_idx] <= min_new;
      max_q[s1_idx] <= max_new;
    end
  end

  // divide magnitude by window length, truncating toward zero
  assign s2_neg  = s2_sum_q[SUM_W-1];
  assign s2_mag  = s2_neg ? SUM_W'(-s2_sum_q) : SUM_W'(s2_sum_q);
  assign s2_prod = PROD_W'(s2_mag) * PROD_W'(DIV_MULT);

  assign s3_idx  = CHIDX_W'(s3_ch_q);
  assign s3_quot = Q_W'(s3_prod_q >> DIV_SHIFT);
  assign avg_new = s3_neg_q ? $signed(SAMPLE_W'(-s3_quot)) : $signed(SAMPLE_W'(s3_quot));
  assign avg_a0  = (s3_idx == CHIDX_W'(0)) ? avg_new : avg_q[0];
  assign avg_a1  = (s3_idx == CHIDX_W'(1)) ? avg_new : avg_q[1];

  always_comb begin
    priority if ((avg_a0 > threshold_q) && (avg_a1 > threshold_q)) begin
      ind_d = IND_OK;
    end else if ((avg_a0 < threshold_q) || (avg_a1 < threshold_q)) begin
      ind_d = IND_ALARM;
    end else begin
      ind_d = ind_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int c = 0; c < NUM_CHANNELS; c++) begin
        avg_q[c] <= '0;
      end
      ind_q <= IND_IDLE;
    end else if (s3_valid_q) begin
      avg_q[s3_idx] <= avg_new;
      ind_q         <= ind_d;
    end
  end

  always_comb begin
    push_data.out_channel = s3_ch_q;
    push_data.average     = avg_new;
    push_data.minimum     = s3_min_q;
    push_data.maximum     = s3_max_q;
    push_data.alarm_state = ind_d;
  end

  assign pop = fifo_valid && out_o.ready;

  mma_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (s3_valid_q),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_o      (head),
    .valid_o     (fifo_valid),
    .count_o     (fifo_count)
  );

  assign out_o.valid       = fifo_valid;
  assign out_o.out_channel = head.out_channel;
  assign out_o.average     = head.average;
  assign out_o.minimum     = head.minimum;
  assign out_o.maximum     = head.maximum;
  assign out_o.alarm_state = head.alarm_state;

endmodule
